>>> sv/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the slot bitmap identifier allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int MAP_SIZE_DEF = 64;
    localparam int ROW_W        = 16;
    localparam int BIT_W        = 4;
    localparam int REL_W        = 6;
    localparam int IDX_W        = 6;
    localparam int ID_W         = 16;
    localparam int ID_BASE_W    = 15;

    localparam logic [ID_BASE_W-1:0] ID_BASE_RST = 15'd300;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_NONE  = 2'd1,
        ST_FREED = 2'd2,
        ST_NOREL = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

endpackage

>>> sv/pba_if.sv
// ----------------------------------------------------------------------------
// pba_req_if / pba_res_if
// Request and result channels of the allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_req_if;
    import pba_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic             holds_slot;
    logic [REL_W-1:0] release_slot;

    modport source (output valid, cmd, holds_slot, release_slot, input ready);
    modport sink   (input valid, cmd, holds_slot, release_slot, output ready);
endinterface

interface pba_res_if;
    import pba_pkg::*;

    logic            valid;
    logic            ready;
    t_status         status;
    logic [IDX_W-1:0] slot_index;
    logic [ID_W-1:0]  id_value;

    modport source (output valid, status, slot_index, id_value, input ready);
    modport sink   (input valid, status, slot_index, id_value, output ready);
endinterface

>>> sv/pid_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// pid_bitmap_allocator
// Identifier allocator over a bitmap of slots held in a row-organised memory.
// ----------------------------------------------------------------------------
// Each request word on i_req gives exactly one result word on o_res. An
// allocate request scans every row of the bitmap memory, one row a cycle,
// then, unless the map is full, reads the chosen row again and writes it
// back with the slot set. A release request reads the named row once and
// writes it back cleared if the slot is held and set. There are ROWS rows,
// MAP_SIZE / 16 rounded up. One request is worked on at a time, and the
// bitmap memory has a registered read port.
// The result sits in an output register, so the next request is accepted
// while a result waits; a stalled receiver holds the block only once the
// following result is ready to be presented.
// Reset is synchronous, frees every slot at once through per-row valid flags
// and leaves the block ready. i_cfg_we writes the identifier base (resets
// to 300), to be used only while idle; the user, not the block, sees to it.
// ----------------------------------------------------------------------------
module pid_bitmap_allocator #(
    parameter int MAP_SIZE = pba_pkg::MAP_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pba_req_if.sink                       i_req,
    pba_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [pba_pkg::ID_BASE_W-1:0] i_cfg_data
);
    import pba_pkg::*;

    localparam int ROWS      = (MAP_SIZE + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MEM_DEPTH = 1 << ROW_AW;
    localparam int FULL_W    = ROW_AW + BIT_W;
    localparam int TOP_SLOT  = MAP_SIZE - 1;

    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
    localparam logic [ROW_AW-1:0] TOP_ROW  = ROW_AW'(TOP_SLOT / ROW_W);
    localparam logic [BIT_W-1:0]  TOP_BIT  = BIT_W'(TOP_SLOT % ROW_W);
    localparam logic [FULL_W:0]   SIZE_EXT = (FULL_W + 1)'(MAP_SIZE);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_MOD    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    logic [ROW_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_row_vld;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;

    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic                r_cmd, n_cmd;
    logic                r_fail, n_fail;
    logic [FULL_W-1:0]   r_target, n_target;
    logic                r_hi_found, n_hi_found;
    logic [FULL_W-1:0]   r_hi_idx, n_hi_idx;
    logic                r_lo_found, n_lo_found;
    logic [FULL_W-1:0]   r_lo_idx, n_lo_idx;
    logic                r_top_used, n_top_used;
    t_status             r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_slot, n_res_slot;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [ID_BASE_W-1:0] r_id_base;

    logic              rd_en;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;

    logic [ROW_W-1:0]  eff_row;
    logic [ROW_W-1:0]  slot_ok;
    logic [ROW_W-1:0]  free_bits;
    logic [BIT_W-1:0]  hi_bit;
    logic [BIT_W-1:0]  lo_bit;
    logic [ID_W-1:0]   rel_ext;
    logic [FULL_W-1:0] rel_full;
    logic              rel_in_range;
    logic [ROW_W-1:0]  tgt_mask;
    logic              out_free;

    assign eff_row  = r_rd_vld ? r_rd_data : '0;
    assign rel_ext  = ID_W'(i_req.release_slot);
    assign rel_full = rel_ext[FULL_W-1:0];
    assign rel_in_range = (rel_ext < ID_W'(MAP_SIZE));
    assign tgt_mask = ROW_W'(1) << r_target[BIT_W-1:0];
    assign out_free = !r_out_vld || o_res.ready;

    always_comb begin
        for (int b = 0; b < ROW_W; b++) begin
            slot_ok[b] = ({1'b0, r_row, BIT_W'(b)} < SIZE_EXT);
        end
        free_bits = ~eff_row & slot_ok;
        hi_bit = '0;
        for (int b = 0; b < ROW_W; b++) begin
            if (eff_row[b]) begin
                hi_bit = BIT_W'(b);
            end
        end
        lo_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                lo_bit = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_cmd        = r_cmd;
        n_fail       = r_fail;
        n_target     = r_target;
        n_hi_found   = r_hi_found;
        n_hi_idx     = r_hi_idx;
        n_lo_found   = r_lo_found;
        n_lo_idx     = r_lo_idx;
        n_top_used   = r_top_used;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_id     = r_out_id;
        rd_en        = 1'b0;
        rd_row       = r_row;
        wr_en        = 1'b0;
        wr_row       = r_target[FULL_W-1:BIT_W];
        wr_data      = eff_row;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd      = i_req.cmd;
                    n_hi_found = 1'b0;
                    n_lo_found = 1'b0;
                    n_top_used = 1'b0;
                    n_row      = '0;
                    rd_en      = 1'b1;
                    if (i_req.cmd == CMD_ALLOC) begin
                        rd_row  = '0;
                        n_fail  = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        rd_row   = rel_full[FULL_W-1:BIT_W];
                        n_target = rel_full;
                        n_fail   = !i_req.holds_slot || !rel_in_range;
                        n_state  = S_MOD;
                    end
                end
            end
            S_SCAN: begin
                if (|eff_row) begin
                    n_hi_found = 1'b1;
                    n_hi_idx   = {r_row, hi_bit};
                end
                if (!r_lo_found && |free_bits) begin
                    n_lo_found = 1'b1;
                    n_lo_idx   = {r_row, lo_bit};
                end
                if (r_row == TOP_ROW) begin
                    n_top_used = eff_row[TOP_BIT];
                end
                if (r_row == LAST_ROW) begin
                    n_state = S_DECIDE;
                end else begin
                    rd_en  = 1'b1;
                    rd_row = r_row + ROW_AW'(1);
                    n_row  = r_row + ROW_AW'(1);
                end
            end
            S_DECIDE: begin
                if (r_top_used) begin
                    n_target = r_lo_idx;
                    n_fail   = !r_lo_found;
                end else if (r_hi_found) begin
                    n_target = r_hi_idx + FULL_W'(1);
                end else begin
                    n_target = '0;
                end
                if (r_top_used && !r_lo_found) begin
                    n_res_status = ST_NONE;
                    n_res_slot   = '0;
                    n_state      = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_row  = n_target[FULL_W-1:BIT_W];
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_res_slot = ID_W'(r_target);
                if (r_cmd == CMD_ALLOC) begin
                    wr_en        = 1'b1;
                    wr_data      = eff_row | tgt_mask;
                    n_res_status = ST_ALLOC;
                end else if (!r_fail && |(eff_row & tgt_mask)) begin
                    wr_en        = 1'b1;
                    wr_data      = eff_row & ~tgt_mask;
                    n_res_status = ST_FREED;
                end else begin
                    n_res_status = ST_NOREL;
                    n_res_slot   = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_slot[IDX_W-1:0];
                    if (r_res_status == ST_ALLOC || r_res_status == ST_FREED) begin
                        n_out_id = r_res_slot + ID_W'(r_id_base);
                    end else begin
                        n_out_id = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_row];
            r_rd_vld  <= r_row_vld[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_id_base <= ID_BASE_RST;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_id_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_cmd        <= n_cmd;
        r_fail       <= n_fail;
        r_target     <= n_target;
        r_hi_found   <= n_hi_found;
        r_hi_idx     <= n_hi_idx;
        r_lo_found   <= n_lo_found;
        r_lo_idx     <= n_lo_idx;
        r_top_used   <= n_top_used;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_id     <= n_out_id;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_vld;
    assign o_res.status     = r_out_status;
    assign o_res.slot_index = r_out_idx;
    assign o_res.id_value   = r_out_id;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("Accepted request did not start processing.");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_vld && r_state == S_IDLE))
        else $error("Finished result was not moved to the output register.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_row <= LAST_ROW))
        else $error("Row scan ran past the last row.");

    a_write_only_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_MOD && !rd_en))
        else $error("Bitmap write outside the modify step.");

    a_write_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_row_vld[$past(wr_row)])
        else $error("Written row was not marked valid.");

endmodule

>>> test/pid_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_bitmap_allocator_tb
// Self-checking testbench for the slot bitmap identifier allocator.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. It covers release with no
// slot held, release of a free slot, filling the map to the top slot, the
// full map, and the switch from above-highest to lowest-free allocation.
// Random phases follow, each with its own identifier base and its own mix of
// allocates and releases. Every result word is checked field by field against
// an in-order queue filled from the typed rows or by a bitmap predictor. The
// sender works in bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module pid_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam int SLOTS       = MAP_SIZE_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 275;
    localparam int DIR_ROWS    = 20;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot_index;
        logic [ID_W-1:0]  id_value;
    } outcome_t;

    typedef struct packed {
        t_cmd             cmd;
        logic             holds;
        logic [REL_W-1:0] rel;
        int               reps;
        bit               typed;
        outcome_t         want;
    } stim_row_t;

    localparam outcome_t NOTHING_HELD = '{ST_NOREL, 6'd0, 16'd0};
    localparam outcome_t MAP_FULL     = '{ST_NONE, 6'd0, 16'd0};

    // Rows typed in are read off directly; the rest go to the predictor.
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_RELEASE, 1'b0, 6'd0,  1,  1'b1, NOTHING_HELD},
        '{CMD_RELEASE, 1'b1, 6'd63, 1,  1'b1, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b1, '{ST_ALLOC, 6'd0, 16'd300}},
        '{CMD_ALLOC,   1'b1, 6'd63, 1,  1'b1, '{ST_ALLOC, 6'd1, 16'd301}},
        '{CMD_RELEASE, 1'b1, 6'd0,  1,  1'b1, '{ST_FREED, 6'd0, 16'd300}},
        '{CMD_RELEASE, 1'b1, 6'd0,  1,  1'b1, NOTHING_HELD},
        '{CMD_RELEASE, 1'b0, 6'd1,  1,  1'b1, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd21, 60, 1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b1, '{ST_ALLOC, 6'd63, 16'd363}},
        '{CMD_ALLOC,   1'b1, 6'd42, 1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b1, MAP_FULL},
        '{CMD_RELEASE, 1'b1, 6'd63, 1,  1'b1, '{ST_FREED, 6'd63, 16'd363}},
        '{CMD_RELEASE, 1'b1, 6'd42, 1,  1'b0, NOTHING_HELD},
        '{CMD_RELEASE, 1'b1, 6'd21, 1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b0, NOTHING_HELD},
        '{CMD_ALLOC,   1'b0, 6'd0,  1,  1'b1, MAP_FULL},
        '{CMD_RELEASE, 1'b0, 6'd63, 1,  1'b1, NOTHING_HELD}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [ID_BASE_W-1:0] cfg_data;

    pba_req_if req_if ();
    pba_res_if res_if ();

    logic [SLOTS-1:0]     slot_used;
    logic [ID_BASE_W-1:0] id_base;
    outcome_t             pending_results [$];
    int                   fail_count;
    int                   words_sent;
    int                   status_tally [4];

    pid_bitmap_allocator #(
        .MAP_SIZE (SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic outcome_t slot_outcome(t_cmd cmd, logic holds, logic [REL_W-1:0] rel);
        outcome_t r;
        int       pick;
        r    = NOTHING_HELD;
        pick = -1;
        if (cmd == CMD_ALLOC) begin
            if (!slot_used[SLOTS-1]) begin
                pick = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i]) pick = i + 1;
            end else begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i]) pick = i;
            end
            if (pick < 0) begin
                r.status = ST_NONE;
            end else begin
                slot_used[pick] = 1'b1;
                r.status        = ST_ALLOC;
            end
        end else if (holds && int'(rel) < SLOTS && slot_used[rel]) begin
            pick            = int'(rel);
            slot_used[pick] = 1'b0;
            r.status        = ST_FREED;
        end
        if (pick >= 0) begin
            r.slot_index = pick[IDX_W-1:0];
            r.id_value   = ID_W'(pick + int'(id_base));
        end
        return r;
    endfunction

    function automatic logic [REL_W-1:0] random_held_slot();
        int held;
        int k;
        held = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i]) held++;
        if (held == 0) return REL_W'($urandom);
        k = $urandom_range(held - 1);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
                if (k == 0) return REL_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < 40)
            $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_cmd cmd, logic holds, logic [REL_W-1:0] rel,
                             bit typed, outcome_t want);
        outcome_t predicted;
        req_if.valid        <= 1'b1;
        req_if.cmd          <= cmd;
        req_if.holds_slot   <= holds;
        req_if.release_slot <= rel;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = slot_outcome(cmd, holds, rel);
        pending_results.push_back(typed ? want : predicted);
        status_tally[predicted.status]++;
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_for(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_id_base(logic [ID_BASE_W-1:0] value);
        wait_drained();
        repeat (12) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        id_base   = value;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, status", int'(res_if.status), -1);
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", int'(res_if.status), int'(want.status));
                if (res_if.slot_index !== want.slot_index)
                    report_mismatch("slot_index", int'(res_if.slot_index),
                                    int'(want.slot_index));
                if (res_if.id_value !== want.id_value)
                    report_mismatch("id_value", int'(res_if.id_value), int'(want.id_value));
            end
        end
    end

    initial begin
        int          mode;
        int          span;
        int          pos;
        int          stall;
        logic [15:0] pat;
        res_if.ready = 1'b0;
        mode  = 0;
        span  = 0;
        pos   = 0;
        stall = 0;
        pat   = '1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (pos == span) begin
                mode  = $urandom_range(3);
                span  = $urandom_range(30, 200);
                pos   = 0;
                pat   = 16'($urandom) | 16'd1;
                stall = $urandom_range(4, 20);
            end
            case (mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= pat[pos % 16];
                2: res_if.ready <= 1'($urandom_range(1));
                default: res_if.ready <= (pos >= stall);
            endcase
            pos++;
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int               alloc_mix [PHASES];
        int               left;
        int               burst;
        int               sel;
        t_cmd             cmd;
        logic             holds;
        logic [REL_W-1:0] rel;
        logic [ID_BASE_W-1:0] base;

        alloc_mix           = '{85, 40, 65, 25, 55, 75};
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_ALLOC;
        req_if.holds_slot   = 1'b0;
        req_if.release_slot = '0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        fail_count          = 0;
        words_sent          = 0;
        status_tally        = '{0, 0, 0, 0};
        slot_used           = '0;
        id_base             = ID_BASE_RST;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_word(directed_rows[r].cmd, directed_rows[r].holds, directed_rows[r].rel,
                          directed_rows[r].typed, directed_rows[r].want);
                if ($urandom_range(2) == 0) idle_for($urandom_range(1, 3));
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: base = '0;
                1: base = '1;
                2: base = ID_BASE_RST;
                default: base = ID_BASE_W'($urandom_range(32767));
            endcase
            set_id_base(base);
            left = PHASE_WORDS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && left > 0; k++) begin
                    if ($urandom_range(99) < alloc_mix[p]) begin
                        cmd   = CMD_ALLOC;
                        holds = 1'($urandom_range(1));
                        rel   = REL_W'($urandom);
                    end else begin
                        cmd = CMD_RELEASE;
                        sel = $urandom_range(9);
                        if (sel < 8) begin
                            holds = 1'b1;
                            rel   = random_held_slot();
                        end else begin
                            holds = (sel == 8);
                            rel   = REL_W'($urandom);
                        end
                    end
                    send_word(cmd, holds, rel, 1'b0, NOTHING_HELD);
                    left--;
                end
                if ($urandom_range(39) == 0)
                    wait_drained();
                else if ($urandom_range(3) != 0)
                    idle_for($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (30) @(negedge i_clk);

        $display("Sent %0d request words over %0d identifier bases: %0d allocated, %0d map full.",
                 words_sent, PHASES + 1, status_tally[ST_ALLOC], status_tally[ST_NONE]);
        $display("Releases: %0d freed, %0d refused; %0d mismatches found.",
                 status_tally[ST_FREED], status_tally[ST_NOREL], fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/pba_pkg.sv
sv/pba_if.sv
sv/pid_bitmap_allocator.sv
test/pid_bitmap_allocator_tb.sv
